// ===== design/pwmd_pkg.sv =====
// Shared types and constants for the pulse-width Manchester decoder.
package pwmd_pkg;

  localparam int DURATION_W  = 15;
  localparam int PERIOD_W    = 15;
  localparam int TOLERANCE_W = 14;
  localparam int STATUS_W    = 3;
  localparam int FRAME_DATA_W = 32;
  localparam int COUNT_W     = 6;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 15;
  localparam int WINDOW_W    = 16;

  localparam int DATA_BITS_DEFAULT = 32;

  localparam logic [PERIOD_W-1:0]    BIT_PERIOD_RESET = PERIOD_W'(833);
  localparam logic [TOLERANCE_W-1:0] TOLERANCE_RESET  = TOLERANCE_W'(105);

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_BIT_PERIOD = 1'b0,
    REG_TOLERANCE  = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PH_START = 2'd0,
    PH_EDGE  = 2'd1,
    PH_MID   = 2'd2,
    PH_HALT  = 2'd3
  } phase_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_BAD_START  = 3'd1,
    ST_BAD_SECOND = 3'd2,
    ST_ENDED_LOW  = 3'd3,
    ST_BAD_WIDTH  = 3'd4
  } status_t;

  typedef struct packed {
    logic level;
    logic last;
    logic padding;
    logic is_half;
    logic is_full;
  } pulse_class_t;

  typedef struct packed {
    status_t                  status;
    logic [FRAME_DATA_W-1:0]  data;
    logic [COUNT_W-1:0]       count;
  } frame_result_t;

endpackage

// ===== design/pwmd_pulse_if.sv =====
// Channel interface that carries one measured pulse per transaction.
interface pwmd_pulse_if;
  logic                                valid;
  logic                                ready;
  logic                                pulse_level;
  logic [pwmd_pkg::DURATION_W-1:0]     pulse_duration;
  logic                                last_pulse;

  modport source (output valid, output pulse_level, output pulse_duration,
                  output last_pulse, input ready);
  modport sink (input valid, input pulse_level, input pulse_duration,
                input last_pulse, output ready);
endinterface

// ===== design/pwmd_frame_if.sv =====
// Channel interface that carries one decoded frame result per transaction.
interface pwmd_frame_if;
  logic                                valid;
  logic                                ready;
  logic [pwmd_pkg::STATUS_W-1:0]       frame_status;
  logic [pwmd_pkg::FRAME_DATA_W-1:0]   frame_data;
  logic [pwmd_pkg::COUNT_W-1:0]        bit_count;

  modport source (output valid, output frame_status, output frame_data,
                  output bit_count, input ready);
  modport sink (input valid, input frame_status, input frame_data,
                input bit_count, output ready);
endinterface

// ===== design/pwmd_cfg_if.sv =====
// Configuration write channel interface: register index and write data.
interface pwmd_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [pwmd_pkg::CFG_INDEX_W-1:0]    reg_index;
  logic [pwmd_pkg::CFG_DATA_W-1:0]     wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

// ===== design/pwmd_decode.sv =====
// Frame decode state machine: applies one classified pulse per step.
module pwmd_decode #(
  parameter int DATA_BITS = pwmd_pkg::DATA_BITS_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    step,
  input  pwmd_pkg::pulse_class_t  pulse,
  output pwmd_pkg::frame_result_t result
);

  pwmd_pkg::phase_t             phase, phase_next;
  logic                         prev_bit, prev_bit_next;
  logic                         pend_level, pend_level_next;
  logic [DATA_BITS-1:0]         shift_data, shift_data_next;
  logic [pwmd_pkg::COUNT_W-1:0] count, count_next;
  pwmd_pkg::status_t            err, err_next;
  logic                         push;
  logic                         push_value;
  logic [pwmd_pkg::FRAME_DATA_W-1:0] data_out;

  always_comb begin
    phase_next = phase;
    if (pulse.padding) begin
      if (phase == pwmd_pkg::PH_START) begin
        phase_next = pwmd_pkg::PH_HALT;
      end else if (phase == pwmd_pkg::PH_MID && !pend_level) begin
        phase_next = pwmd_pkg::PH_HALT;
      end
    end else begin
      unique case (phase)
        pwmd_pkg::PH_START: begin
          phase_next = (pulse.level && pulse.is_half) ? pwmd_pkg::PH_EDGE : pwmd_pkg::PH_HALT;
        end
        pwmd_pkg::PH_EDGE: begin
          if (pulse.is_half) begin
            if (pulse.last) begin
              if (!pulse.level) begin
                phase_next = pwmd_pkg::PH_HALT;
              end
            end else begin
              phase_next = pwmd_pkg::PH_MID;
            end
          end else if (!pulse.is_full) begin
            phase_next = pwmd_pkg::PH_HALT;
          end
        end
        pwmd_pkg::PH_MID: begin
          phase_next = pulse.is_half ? pwmd_pkg::PH_EDGE : pwmd_pkg::PH_HALT;
        end
        pwmd_pkg::PH_HALT: begin
          phase_next = pwmd_pkg::PH_HALT;
        end
      endcase
    end
  end

  always_comb begin
    err_next        = err;
    prev_bit_next   = prev_bit;
    pend_level_next = pend_level;
    push            = 1'b0;
    push_value      = prev_bit;
    if (pulse.padding) begin
      if (phase == pwmd_pkg::PH_START) begin
        err_next = pwmd_pkg::ST_BAD_START;
      end else if (phase == pwmd_pkg::PH_MID && !pend_level) begin
        err_next = pwmd_pkg::ST_ENDED_LOW;
      end
    end else begin
      unique case (phase)
        pwmd_pkg::PH_START: begin
          if (!(pulse.level && pulse.is_half)) begin
            err_next = pwmd_pkg::ST_BAD_START;
          end
        end
        pwmd_pkg::PH_EDGE: begin
          if (pulse.is_half) begin
            if (pulse.last) begin
              if (!pulse.level) begin
                err_next = pwmd_pkg::ST_ENDED_LOW;
              end
            end else begin
              pend_level_next = pulse.level;
            end
          end else if (pulse.is_full) begin
            prev_bit_next = ~prev_bit;
            push          = 1'b1;
            push_value    = ~prev_bit;
          end else begin
            err_next = pwmd_pkg::ST_BAD_WIDTH;
          end
        end
        pwmd_pkg::PH_MID: begin
          if (pulse.is_half) begin
            push = 1'b1;
          end else begin
            err_next = pwmd_pkg::ST_BAD_SECOND;
          end
        end
        pwmd_pkg::PH_HALT: begin
          push = 1'b0;
        end
      endcase
    end
    shift_data_next = push ? {shift_data[DATA_BITS-2:0], push_value} : shift_data;
    count_next      = (push && count != '1) ? count + 1'b1 : count;
  end

  always_comb begin
    result.status = err_next;
    result.data   = data_out;
    result.count  = count_next;
  end

  if (DATA_BITS >= pwmd_pkg::FRAME_DATA_W) begin : g_data_wide
    assign data_out = shift_data_next[pwmd_pkg::FRAME_DATA_W-1:0];
  end else begin : g_data_narrow
    assign data_out = {{(pwmd_pkg::FRAME_DATA_W-DATA_BITS){1'b0}}, shift_data_next};
  end

  always_ff @(posedge clk) begin
    if (rst || (step && pulse.last)) begin
      phase      <= pwmd_pkg::PH_START;
      prev_bit   <= 1'b1;
      pend_level <= 1'b0;
      shift_data <= '0;
      count      <= '0;
      err        <= pwmd_pkg::ST_OK;
    end else if (step) begin
      phase      <= phase_next;
      prev_bit   <= prev_bit_next;
      pend_level <= pend_level_next;
      shift_data <= shift_data_next;
      count      <= count_next;
      err        <= err_next;
    end
  end

endmodule

// ===== design/pulse_width_manchester_decoder.sv =====
// Top level of the pulse-width Manchester frame decoder.
// Output: a frame result is registered in the output register once its last pulse leaves the input register.
// Throughput: one pulse per cycle; the input stalls only while a last pulse waits in the
// input register behind a result that has not been taken.
// Reset: clears all valid flags and frame state and loads the timing registers with
// 833 us bit period and 105 us tolerance.
module pulse_width_manchester_decoder #(
  parameter int DATA_BITS = pwmd_pkg::DATA_BITS_DEFAULT
) (
  input logic          clk,
  input logic          rst,
  pwmd_pulse_if.sink   pulse,
  pwmd_frame_if.source frame,
  pwmd_cfg_if.sink     cfg
);

  logic [pwmd_pkg::PERIOD_W-1:0]    bit_period;
  logic [pwmd_pkg::TOLERANCE_W-1:0] tolerance;

  logic [pwmd_pkg::WINDOW_W-1:0] dur_w, tol_w, half_w, full_w;
  pwmd_pkg::pulse_class_t        pulse_class;
  pwmd_pkg::pulse_class_t        s1_pulse;
  logic                          s1_valid;
  logic                          s1_stall;
  logic                          s1_fire;
  pwmd_pkg::frame_result_t       result;
  logic                          out_valid;
  pwmd_pkg::frame_result_t       out_result;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_period <= pwmd_pkg::BIT_PERIOD_RESET;
      tolerance  <= pwmd_pkg::TOLERANCE_RESET;
    end else if (cfg.valid) begin
      unique case (pwmd_pkg::cfg_reg_t'(cfg.reg_index))
        pwmd_pkg::REG_BIT_PERIOD: bit_period <= cfg.wdata[pwmd_pkg::PERIOD_W-1:0];
        pwmd_pkg::REG_TOLERANCE:  tolerance  <= cfg.wdata[pwmd_pkg::TOLERANCE_W-1:0];
      endcase
    end
  end

  // Window tests are rewritten as dur + tol > nominal so nothing goes negative.
  always_comb begin
    dur_w  = {1'b0, pulse.pulse_duration};
    tol_w  = {2'b0, tolerance};
    half_w = {2'b0, bit_period[pwmd_pkg::PERIOD_W-1:1]};
    full_w = {1'b0, bit_period};
    pulse_class.level   = pulse.pulse_level;
    pulse_class.last    = pulse.last_pulse;
    pulse_class.padding = pulse.last_pulse && !pulse.pulse_level && (pulse.pulse_duration == '0);
    pulse_class.is_half = (dur_w + tol_w > half_w) && (dur_w < half_w + tol_w);
    pulse_class.is_full = (dur_w + tol_w > full_w) && (dur_w < full_w + tol_w);
  end

  assign s1_stall    = s1_valid && s1_pulse.last && out_valid && !frame.ready;
  assign s1_fire     = s1_valid && !s1_stall;
  assign pulse.ready = !s1_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pulse.ready) begin
      s1_valid <= pulse.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pulse.ready && pulse.valid) begin
      s1_pulse <= pulse_class;
    end
  end

  pwmd_decode #(
    .DATA_BITS (DATA_BITS)
  ) u_decode (
    .clk    (clk),
    .rst    (rst),
    .step   (s1_fire),
    .pulse  (s1_pulse),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && s1_pulse.last) begin
      out_valid <= 1'b1;
    end else if (frame.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_pulse.last) begin
      out_result <= result;
    end
  end

  assign frame.valid        = out_valid;
  assign frame.frame_status = out_result.status;
  assign frame.frame_data   = out_result.data;
  assign frame.bit_count    = out_result.count;

endmodule
